### hdl/sparse_polynomial_term_table_macros.svh
// ----------------------------------------------------------------------------
// sparse polynomial term table assertion macros
// shared property shapes for the checker
// ----------------------------------------------------------------------------
`ifndef SPARSE_POLYNOMIAL_TERM_TABLE_MACROS_SVH
`define SPARSE_POLYNOMIAL_TERM_TABLE_MACROS_SVH

// same-cycle implication
`define SPTT_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sptt check failed");

// next-cycle implication
`define SPTT_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sptt check failed");

`endif

### hdl/sptt_pkg.sv
// ----------------------------------------------------------------------------
// sptt_pkg
// types and codes shared by the sparse polynomial term table and its checker
// ----------------------------------------------------------------------------
package sptt_pkg;

   // action codes
   localparam logic [1:0] ACT_INSERT = 2'd0;
   localparam logic [1:0] ACT_EVAL   = 2'd1;
   localparam logic [1:0] ACT_DERIV  = 2'd2;
   localparam logic [1:0] ACT_CLEAR  = 2'd3;

   // status codes
   localparam logic [1:0] STAT_OK   = 2'd0;
   localparam logic [1:0] STAT_FULL = 2'd1;
   localparam logic [1:0] STAT_SAT  = 2'd2;

   localparam logic [63:0] TOP64 = 64'h8000_0000_0000_0000;
   localparam logic [63:0] POS64 = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] ONE64 = 64'h0000_0001_0000_0000;

   typedef struct packed {
      logic [1:0]         action;
      logic signed [31:0] coef;
      logic [5:0]         exponent;
      logic signed [31:0] x;
   } req_type;

   typedef struct packed {
      logic signed [63:0] value;
      logic [1:0]         status;
      logic [5:0]         term_count;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SCAN_RD, ST_SCAN_CHK, ST_MOVE_RD, ST_MOVE_WR,
      ST_EVAL_RD, ST_EVAL_LOAD, ST_POW_MUL, ST_POW_DONE,
      ST_TERM_MUL, ST_TERM_DONE, ST_ACC, ST_DONE
   } state_type;

endpackage

### hdl/sparse_polynomial_term_table.sv
// ----------------------------------------------------------------------------
// sparse_polynomial_term_table
// sorted table of polynomial terms with insert, evaluate, derivative, clear
// ----------------------------------------------------------------------------
// Terms live in one single-port-write memory with a registered read, kept in
// descending exponent order. An item is taken when start is high and busy is
// low; its one result shows on rsp for a single cycle with rsp_valid high,
// and the receiver cannot stall it. Clear and a zero-coefficient insert go
// straight to the result. Insert scans entries and then shifts entries to
// open or close a gap. Evaluate and derivative walk the terms through the
// 32x32 multiplier, which builds each 64x64 product in four partial
// products, one per cycle.
// ----------------------------------------------------------------------------
module sparse_polynomial_term_table #(
   parameter int MAX_TERMS = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  sptt_pkg::req_type req,
   output logic             busy,
   output logic             rsp_valid,
   output sptt_pkg::rsp_type rsp
);
   import sptt_pkg::*;

   localparam int AW = $clog2(MAX_TERMS);
   localparam int CW = $clog2(MAX_TERMS + 1);

   typedef struct packed {
      logic [31:0] coef;
      logic [5:0]  expo;
   } entry_type;

   // term memory
   entry_type      mem [MAX_TERMS];
   entry_type      rd_data_ff;
   logic [AW-1:0]  rd_addr;
   logic           wr_en;
   logic [AW-1:0]  wr_addr;
   entry_type      wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   state_type     state_ff, state_in;
   req_type       req_ff, req_in;
   logic [CW-1:0] n_ff, n_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] j_ff, j_in;
   logic          up_ff, up_in;
   logic [5:0]    k_ff, k_in;
   logic [63:0]   m_ff, m_in;
   logic          neg_ff, neg_in;
   logic [63:0]   a_ff, a_in;
   logic [63:0]   b_ff, b_in;
   logic [127:0]  prod_ff, prod_in;
   logic [1:0]    step_ff, step_in;
   logic [63:0]   acc_ff, acc_in;
   logic [63:0]   t_ff, t_in;
   logic          sat_ff, sat_in;
   logic [1:0]    st_ff, st_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   // datapath helpers
   logic [31:0]   xm;
   logic          xneg;
   logic [5:0]    cur_exp;
   logic [31:0]   cur_coef;
   logic [31:0]   coef_mag;
   logic          deriv;
   logic [5:0]    pe;
   logic [37:0]   mprod;
   logic signed [32:0] msum;
   logic [31:0]   msum_sat;
   logic          msum_ovf;
   logic [31:0]   a_half, b_half;
   logic [63:0]   pp;
   logic [127:0]  pp_sh;
   logic          pw_over;
   logic [63:0]   pw_val;
   logic [63:0]   p_next;
   logic          tm_over;
   logic [63:0]   tm_mag;
   logic [63:0]   acc_sum;
   logic [CW:0]   j_plus;

   assign xneg     = req_ff.x[31];
   assign xm       = xneg ? (~req_ff.x + 32'd1) : req_ff.x;
   assign cur_exp  = rd_data_ff.expo;
   assign cur_coef = rd_data_ff.coef;
   assign coef_mag = cur_coef[31] ? (~cur_coef + 32'd1) : cur_coef;
   assign deriv    = (req_ff.action == ACT_DERIV);
   assign pe       = deriv ? (cur_exp - 6'd1) : cur_exp;
   assign mprod    = 38'(coef_mag) * 38'(deriv ? cur_exp : 6'd1);
   assign j_plus   = {1'b0, j_ff} + {{CW{1'b0}}, 1'b1};

   // coefficient merge with saturation
   assign msum     = $signed({cur_coef[31], cur_coef}) + $signed({req_ff.coef[31], req_ff.coef});
   assign msum_ovf = msum[32] != msum[31];
   assign msum_sat = msum_ovf ? (msum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF) : msum[31:0];

   // one 32x32 partial product per cycle
   assign a_half = step_ff[0] ? a_ff[63:32] : a_ff[31:0];
   assign b_half = step_ff[1] ? b_ff[63:32] : b_ff[31:0];
   assign pp     = 64'(a_half) * 64'(b_half);

   always_comb begin
      case (step_ff)
         2'd0:    pp_sh = {64'd0, pp};
         2'd3:    pp_sh = {pp, 64'd0};
         default: pp_sh = {32'd0, pp, 32'd0};
      endcase
   end

   // power step rescale and clamp
   assign pw_over = (prod_ff >> (64 + FRAC_BITS)) != 128'd0;
   assign pw_val  = 64'(prod_ff >> FRAC_BITS);
   assign p_next  = (pw_over || pw_val > TOP64) ? TOP64 : pw_val;

   // term magnitude clamp
   assign tm_over = (prod_ff[127:64] != 64'd0) || (prod_ff[63:0] > TOP64);
   assign tm_mag  = tm_over ? TOP64 : prod_ff[63:0];

   assign acc_sum = acc_ff + t_ff;

   // next state and datapath control
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      n_in         = n_ff;
      idx_in       = idx_ff;
      j_in         = j_ff;
      up_in        = up_ff;
      k_in         = k_ff;
      m_in         = m_ff;
      neg_in       = neg_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      prod_in      = prod_ff;
      step_in      = step_ff;
      acc_in       = acc_ff;
      t_in         = t_ff;
      sat_in       = sat_ff;
      st_in        = st_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      rd_addr      = idx_ff[AW-1:0];
      wr_en        = 1'b0;
      wr_addr      = idx_ff[AW-1:0];
      wr_data      = {req_ff.coef, req_ff.exponent};

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in = req;
               idx_in = '0;
               acc_in = '0;
               sat_in = 1'b0;
               st_in  = STAT_OK;
               case (req.action)
                  ACT_INSERT: state_in = (req.coef == 32'sd0) ? ST_DONE : ST_SCAN_RD;
                  ACT_CLEAR: begin
                     n_in     = '0;
                     state_in = ST_DONE;
                  end
                  default: state_in = ST_EVAL_RD;
               endcase
            end
         end

         // find the first entry whose exponent is not above the new one
         ST_SCAN_RD: begin
            if (idx_ff == n_ff) begin
               if (n_ff == CW'(MAX_TERMS)) begin
                  st_in    = STAT_FULL;
                  state_in = ST_DONE;
               end else begin
                  up_in    = 1'b1;
                  j_in     = n_ff;
                  state_in = ST_MOVE_RD;
               end
            end else begin
               state_in = ST_SCAN_CHK;
            end
         end

         ST_SCAN_CHK: begin
            if (cur_exp > req_ff.exponent) begin
               idx_in   = idx_ff + CW'(1);
               state_in = ST_SCAN_RD;
            end else if (cur_exp == req_ff.exponent) begin
               if (msum == 33'sd0) begin
                  up_in    = 1'b0;
                  j_in     = idx_ff;
                  state_in = ST_MOVE_RD;
               end else begin
                  wr_en    = 1'b1;
                  wr_data  = {msum_sat, cur_exp};
                  st_in    = msum_ovf ? STAT_SAT : STAT_OK;
                  state_in = ST_DONE;
               end
            end else if (n_ff == CW'(MAX_TERMS)) begin
               st_in    = STAT_FULL;
               state_in = ST_DONE;
            end else begin
               up_in    = 1'b1;
               j_in     = n_ff;
               state_in = ST_MOVE_RD;
            end
         end

         // shift entries up to open a gap or down to close one
         ST_MOVE_RD: begin
            if (up_ff) begin
               if (j_ff == idx_ff) begin
                  wr_en    = 1'b1;
                  n_in     = n_ff + CW'(1);
                  state_in = ST_DONE;
               end else begin
                  rd_addr  = AW'(j_ff - CW'(1));
                  state_in = ST_MOVE_WR;
               end
            end else begin
               if (j_plus == {1'b0, n_ff}) begin
                  n_in     = n_ff - CW'(1);
                  state_in = ST_DONE;
               end else begin
                  rd_addr  = AW'(j_plus);
                  state_in = ST_MOVE_WR;
               end
            end
         end

         ST_MOVE_WR: begin
            wr_en    = 1'b1;
            wr_addr  = j_ff[AW-1:0];
            wr_data  = rd_data_ff;
            j_in     = up_ff ? (j_ff - CW'(1)) : j_plus[CW-1:0];
            state_in = ST_MOVE_RD;
         end

         // walk the terms in table order
         ST_EVAL_RD: begin
            if (idx_ff == n_ff) begin
               st_in    = sat_ff ? STAT_SAT : STAT_OK;
               state_in = ST_DONE;
            end else begin
               state_in = ST_EVAL_LOAD;
            end
         end

         ST_EVAL_LOAD: begin
            if (deriv && cur_exp == 6'd0) begin
               idx_in   = idx_ff + CW'(1);
               state_in = ST_EVAL_RD;
            end else begin
               m_in    = 64'(mprod);
               neg_in  = cur_coef[31] ^ (xneg & pe[0]);
               k_in    = pe;
               prod_in = '0;
               step_in = '0;
               if (pe == 6'd0) begin
                  a_in     = 64'(mprod);
                  b_in     = ONE64;
                  state_in = ST_TERM_MUL;
               end else begin
                  a_in     = ONE64;
                  b_in     = 64'(xm);
                  state_in = ST_POW_MUL;
               end
            end
         end

         ST_POW_MUL, ST_TERM_MUL: begin
            prod_in = prod_ff + pp_sh;
            step_in = step_ff + 2'd1;
            if (step_ff == 2'd3)
               state_in = (state_ff == ST_POW_MUL) ? ST_POW_DONE : ST_TERM_DONE;
         end

         ST_POW_DONE: begin
            if (pw_over || pw_val > TOP64) sat_in = 1'b1;
            k_in    = k_ff - 6'd1;
            prod_in = '0;
            step_in = '0;
            if (k_ff == 6'd1) begin
               a_in     = m_ff;
               b_in     = p_next;
               state_in = ST_TERM_MUL;
            end else begin
               a_in     = p_next;
               b_in     = 64'(xm);
               state_in = ST_POW_MUL;
            end
         end

         ST_TERM_DONE: begin
            if (tm_over) sat_in = 1'b1;
            if (neg_ff) begin
               t_in = ~tm_mag + 64'd1;
            end else if (tm_mag > POS64) begin
               t_in   = POS64;
               sat_in = 1'b1;
            end else begin
               t_in = tm_mag;
            end
            state_in = ST_ACC;
         end

         // saturating accumulate
         ST_ACC: begin
            if (acc_ff[63] == t_ff[63] && acc_sum[63] != acc_ff[63]) begin
               acc_in = acc_ff[63] ? TOP64 : POS64;
               sat_in = 1'b1;
            end else begin
               acc_in = acc_sum;
            end
            idx_in   = idx_ff + CW'(1);
            state_in = ST_EVAL_RD;
         end

         ST_DONE: begin
            rsp_valid_in      = 1'b1;
            rsp_in.value      = acc_ff;
            rsp_in.status     = st_ff;
            rsp_in.term_count = 6'(n_ff);
            state_in          = ST_IDLE;
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         n_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         n_ff         <= n_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      idx_ff  <= idx_in;
      j_ff    <= j_in;
      up_ff   <= up_in;
      k_ff    <= k_in;
      m_ff    <= m_in;
      neg_ff  <= neg_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      prod_ff <= prod_in;
      step_ff <= step_in;
      acc_ff  <= acc_in;
      t_ff    <= t_in;
      sat_ff  <= sat_in;
      st_ff   <= st_in;
      rsp_ff  <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

### hdl/sptt_checker.sv
// ----------------------------------------------------------------------------
// sptt_checker
// port-level checks for the sparse polynomial term table
// ----------------------------------------------------------------------------
`include "sparse_polynomial_term_table_macros.svh"

module sptt_checker #(
   parameter int MAX_TERMS = 32
) (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input sptt_pkg::req_type req,
   input logic              busy,
   input logic              rsp_valid,
   input sptt_pkg::rsp_type rsp
);
   import sptt_pkg::*;

   logic taken;
   assign taken = start && !busy;

   // a taken transfer always leaves the block busy in the next cycle
   `SPTT_ASSERT_NXT(a_take_busy, clock, reset, taken, busy)
   // a result only appears once the block has gone idle
   `SPTT_ASSERT_IMP(a_rsp_idle, clock, reset, rsp_valid, !busy)
   // results are single-cycle strobes
   `SPTT_ASSERT_NXT(a_rsp_pulse, clock, reset, rsp_valid, !rsp_valid)
   // status code is meaningful and count within capacity
   `SPTT_ASSERT_IMP(a_rsp_sane, clock, reset, rsp_valid,
      rsp.status != 2'd3 && (MAX_TERMS > 63 || rsp.term_count <= MAX_TERMS))

endmodule

bind sparse_polynomial_term_table sptt_checker #(.MAX_TERMS(MAX_TERMS)) u_sptt_checker (.*);

### sim/sparse_polynomial_term_table_test.sv
// ----------------------------------------------------------------------------
// sparse_polynomial_term_table_test
// drives insert, evaluate, derivative and clear commands into the term table
// and checks every result against a local model of the sorted term list
// ----------------------------------------------------------------------------
module sparse_polynomial_term_table_test;
   timeunit 1ns;
   timeprecision 1ps;
   import sptt_pkg::*;

   localparam int TABLE_DEPTH = 32;
   localparam int FRAC = 16;
   localparam longint CYCLE_LIMIT = 64'd80000000;

   logic    clock;
   logic    reset;
   logic    start;
   req_type req;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp;

   sparse_polynomial_term_table #(.MAX_TERMS(TABLE_DEPTH), .FRAC_BITS(FRAC)) dut (
      .clock(clock), .reset(reset), .start(start), .req(req),
      .busy(busy), .rsp_valid(rsp_valid), .rsp(rsp)
   );

   // shadow copy of the term table
   logic [31:0] shadow_coef [TABLE_DEPTH];
   logic [5:0]  shadow_exp  [TABLE_DEPTH];
   int          shadow_count;

   rsp_type pending_results [$];
   int      error_count;
   longint  cycle_count;
   int      send_idle_pct;

   // directed rows: request, typed-in result, and whether that result is used
   typedef struct {
      req_type cmd;
      rsp_type known;
      bit      has_known;
   } directed_row_type;

   function automatic logic [63:0] magnitude32(logic [31:0] v);
      return v[31] ? {32'd0, -v} : {32'd0, v};
   endfunction

   // polynomial or slope value with saturation flag
   function automatic logic [63:0] evaluate_terms(logic [31:0] xb, bit slope, output bit sat);
      logic [63:0]  acc, xm, m, p, mag, t, s;
      logic [127:0] prod;
      int           e, pe;
      bit           neg;
      acc = 0;
      sat = 0;
      xm = magnitude32(xb);
      for (int i = 0; i < shadow_count; i++) begin
         e = shadow_exp[i];
         if (slope && e == 0) continue;
         pe = slope ? e - 1 : e;
         m = magnitude32(shadow_coef[i]);
         if (slope) m = m * e;
         p = ONE64;
         for (int k = 0; k < pe; k++) begin
            prod = p * xm;
            if (prod[127:64+FRAC] != 0) begin
               p = TOP64;
               sat = 1;
            end else begin
               p = prod[63+FRAC:FRAC];
               if (p > TOP64) begin
                  p = TOP64;
                  sat = 1;
               end
            end
         end
         prod = m * p;
         mag = prod[63:0];
         if (prod[127:64] != 0 || mag > TOP64) begin
            mag = TOP64;
            sat = 1;
         end
         neg = shadow_coef[i][31] != (xb[31] && pe[0]);
         if (neg) t = -mag;
         else if (mag > POS64) begin
            t = POS64;
            sat = 1;
         end else t = mag;
         s = acc + t;
         if (acc[63] == t[63] && s[63] != acc[63]) begin
            s = acc[63] ? TOP64 : POS64;
            sat = 1;
         end
         acc = s;
      end
      return acc;
   endfunction

   function automatic logic [1:0] insert_term(logic [31:0] c, logic [5:0] e);
      int     pos;
      longint sum;
      logic [1:0] st;
      pos = 0;
      st = STAT_OK;
      if (c == 0) return STAT_OK;
      while (pos < shadow_count && shadow_exp[pos] > e) pos++;
      if (pos < shadow_count && shadow_exp[pos] == e) begin
         sum = longint'($signed(shadow_coef[pos])) + longint'($signed(c));
         if (sum > 64'sd2147483647) begin
            sum = 64'sd2147483647;
            st = STAT_SAT;
         end else if (sum < -64'sd2147483648) begin
            sum = -64'sd2147483648;
            st = STAT_SAT;
         end
         if (sum == 0) begin
            for (int j = pos; j + 1 < shadow_count; j++) begin
               shadow_coef[j] = shadow_coef[j+1];
               shadow_exp[j] = shadow_exp[j+1];
            end
            shadow_count--;
         end else shadow_coef[pos] = sum[31:0];
         return st;
      end
      if (shadow_count >= TABLE_DEPTH) return STAT_FULL;
      for (int j = shadow_count; j > pos; j--) begin
         shadow_coef[j] = shadow_coef[j-1];
         shadow_exp[j] = shadow_exp[j-1];
      end
      shadow_coef[pos] = c;
      shadow_exp[pos] = e;
      shadow_count++;
      return STAT_OK;
   endfunction

   function automatic rsp_type predict_result(req_type r);
      rsp_type o;
      bit      sat;
      o = '0;
      case (r.action)
         ACT_INSERT: o.status = insert_term(r.coef, r.exponent);
         ACT_EVAL, ACT_DERIV: begin
            o.value = evaluate_terms(r.x, r.action == ACT_DERIV, sat);
            o.status = sat ? STAT_SAT : STAT_OK;
         end
         default: shadow_count = 0;
      endcase
      o.term_count = shadow_count[5:0];
      return o;
   endfunction

   // clock and cycle limit
   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t timeout", $time);
         $display("sparse_polynomial_term_table_test: errors");
         $finish;
      end
   end

   // result checking, one transfer per strobe
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            error_count++;
            $display("%0t unexpected result value=%h status=%0d count=%0d",
                     $time, rsp.value, rsp.status, rsp.term_count);
         end else begin
            want = pending_results.pop_front();
            if (rsp.value !== want.value) begin
               error_count++;
               $display("%0t value expected %h actual %h", $time, want.value, rsp.value);
            end
            if (rsp.status !== want.status) begin
               error_count++;
               $display("%0t status expected %0d actual %0d", $time, want.status, rsp.status);
            end
            if (rsp.term_count !== want.term_count) begin
               error_count++;
               $display("%0t term_count expected %0d actual %0d",
                        $time, want.term_count, rsp.term_count);
            end
         end
      end
   end

   // issue one command transfer, optional typed-in result checked too
   // start stays high after the transfer until the next idle cycle or command
   task automatic issue_command(req_type r, bit has_known, rsp_type known);
      rsp_type p;
      while ($urandom_range(99) < send_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      p = predict_result(r);
      if (has_known && p !== known) begin
         error_count++;
         $display("%0t table row expected %h model %h", $time, known, p);
      end
      pending_results.push_back(p);
   endtask

   function automatic req_type make_cmd(logic [1:0] a, logic [31:0] c, logic [5:0] e,
                                        logic [31:0] x);
      req_type r;
      r.action = a;
      r.coef = c;
      r.exponent = e;
      r.x = x;
      return r;
   endfunction

   function automatic rsp_type make_rsp(logic [63:0] v, logic [1:0] s, logic [5:0] n);
      rsp_type o;
      o.value = v;
      o.status = s;
      o.term_count = n;
      return o;
   endfunction

   // random command, mostly inserts, with exponents from 0 to 63
   function automatic req_type random_cmd();
      req_type r;
      int      pick;
      pick = $urandom_range(99);
      r.action = pick < 55 ? ACT_INSERT : pick < 75 ? ACT_EVAL : pick < 96 ? ACT_DERIV : ACT_CLEAR;
      case ($urandom_range(3))
         0: r.coef = $urandom;
         1: r.coef = $urandom_range(15) - 8;
         2: r.coef = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: r.coef = $urandom_range(2000) - 1000;
      endcase
      r.exponent = $urandom_range(1) ? $urandom_range(63) : $urandom_range(40);
      case ($urandom_range(3))
         0: r.x = $urandom;
         1: r.x = $urandom_range(32'h0003_0000) - 32'h0001_8000;
         2: r.x = $urandom_range(1) ? 32'h0001_0000 : 32'hFFFF_0000;
         default: r.x = $urandom_range(32'h0000_FFFF);
      endcase
      return r;
   endfunction

   initial begin
      directed_row_type rows [$];
      rsp_type          none;
      int               hold;
      none = '0;
      error_count = 0;
      cycle_count = 0;
      shadow_count = 0;
      send_idle_pct = 0;
      start = 0;
      req = '0;
      reset = 1;
      repeat (8) @(posedge clock);
      reset <= 0;

      // directed table
      rows.push_back('{make_cmd(ACT_EVAL, 0, 0, 32'h0001_0000), make_rsp(0, STAT_OK, 0), 1});
      rows.push_back('{make_cmd(ACT_DERIV, 0, 0, 32'h8000_0000), make_rsp(0, STAT_OK, 0), 1});
      rows.push_back('{make_cmd(ACT_INSERT, 0, 5, 0), make_rsp(0, STAT_OK, 0), 1});
      rows.push_back('{make_cmd(ACT_INSERT, 32'h7FFF_FFFF, 63, 0), make_rsp(0, STAT_OK, 1), 1});
      rows.push_back('{make_cmd(ACT_INSERT, 1, 63, 0), make_rsp(0, STAT_SAT, 1), 1});
      rows.push_back('{make_cmd(ACT_INSERT, 32'h8000_0000, 0, 0), make_rsp(0, STAT_OK, 2), 1});
      rows.push_back('{make_cmd(ACT_INSERT, 32'hFFFF_FFFF, 0, 0), make_rsp(0, STAT_SAT, 2), 1});
      rows.push_back('{make_cmd(ACT_EVAL, 0, 0, 32'h7FFF_FFFF), none, 0});
      rows.push_back('{make_cmd(ACT_DERIV, 0, 0, 32'h8000_0000), none, 0});
      rows.push_back('{make_cmd(ACT_EVAL, 0, 0, 0), none, 0});
      rows.push_back('{make_cmd(ACT_INSERT, 32'h8000_0001, 63, 0), make_rsp(0, STAT_OK, 1), 1});
      rows.push_back('{make_cmd(ACT_INSERT, 3, 1, 0), make_rsp(0, STAT_OK, 2), 1});
      rows.push_back('{make_cmd(ACT_EVAL, 0, 0, 32'hFFFF_0000), none, 0});
      rows.push_back('{make_cmd(ACT_DERIV, 0, 0, 32'h0000_8000), none, 0});
      rows.push_back('{make_cmd(ACT_INSERT, -3, 1, 0), make_rsp(0, STAT_OK, 1), 1});
      rows.push_back('{make_cmd(ACT_CLEAR, 0, 0, 0), make_rsp(0, STAT_OK, 0), 1});
      foreach (rows[i]) issue_command(rows[i].cmd, rows[i].has_known, rows[i].known);

      // fill to capacity, then a dropped insert and a merge while full
      for (int e = 0; e < TABLE_DEPTH; e++)
         issue_command(make_cmd(ACT_INSERT, e + 1, 6'(e * 2), 0), 0, none);
      issue_command(make_cmd(ACT_INSERT, 9, 1, 0), 1, make_rsp(0, STAT_FULL, 32));
      issue_command(make_cmd(ACT_INSERT, 9, 2, 0), 1, make_rsp(0, STAT_OK, 32));
      issue_command(make_cmd(ACT_EVAL, 0, 0, 32'h0000_F000), 0, none);
      issue_command(make_cmd(ACT_CLEAR, 0, 0, 0), 1, make_rsp(0, STAT_OK, 0));

      // random phases with different sender idling
      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = phase == 0 ? 0 : phase == 1 ? 70 : phase == 2 ? 29 : 0;
         for (int n = 0; n < 420; n++) begin
            issue_command(random_cmd(), 0, none);
            // hold off until the block has drained
            if (phase == 3 && n == 200) begin
               start <= 1'b0;
               hold = 0;
               while (pending_results.size() != 0 && hold < 200000) begin
                  @(posedge clock);
                  hold++;
               end
            end
         end
      end

      start <= 1'b0;
      hold = 0;
      while (pending_results.size() != 0 && hold < 200000) begin
         @(posedge clock);
         hold++;
      end
      repeat (50) @(posedge clock);
      if (error_count == 0 && pending_results.size() == 0)
         $display("sparse_polynomial_term_table_test: clean");
      else
         $display("sparse_polynomial_term_table_test: errors");
      $finish;
   end
endmodule
